### design/lcbr_pkg.sv
// ----------------------------------------------------------------------------
// lcbr_pkg
// Types, character codes and message text of the LED command and button
// reporter.
// ----------------------------------------------------------------------------
package lcbr_pkg;

  localparam int BUTTONS = 7;

  localparam logic [7:0] CH_L      = 8'h4C;  // 'L'
  localparam logic [7:0] CH_R      = 8'h52;  // 'R'
  localparam logic [7:0] CH_G      = 8'h47;  // 'G'
  localparam logic [7:0] CH_B      = 8'h42;  // 'B'
  localparam logic [7:0] CH_G_LOW  = 8'h67;  // 'g'
  localparam logic [7:0] CH_T      = 8'h54;  // 'T'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE    = 8'h31;  // '1'
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [1:0] PARSE_START  = 2'd0;
  localparam logic [1:0] PARSE_LETTER = 2'd1;
  localparam logic [1:0] PARSE_ACTION = 2'd2;

  localparam logic [1:0] LED_RED    = 2'd0;
  localparam logic [1:0] LED_GREEN  = 2'd1;
  localparam logic [1:0] LED_BLUE   = 2'd2;
  localparam logic [1:0] LED_GREEN2 = 2'd3;

  // one tick as classified by the front end
  typedef struct packed {
    logic [3:0]         leds;
    logic [BUTTONS-1:0] changed;
    logic [BUTTONS-1:0] pressed;
    logic               tx_ready;
  } job_t;

  function automatic logic [2:0] name_len(input logic [2:0] btn);
    logic [2:0] n;
    case (btn)
      3'd2:    n = 3'd5;
      3'd3:    n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] msg_len(input logic [2:0] btn, input logic released);
    logic [4:0] n;
    n = 5'(name_len(btn)) + (released ? 5'd9 : 5'd8) + 5'd2;
    return n;
  endfunction

  // byte k of "<NAME> PRESSED|RELEASED" CR LF
  function automatic logic [7:0] msg_byte(input logic [2:0] btn, input logic released,
                                          input logic [3:0] k);
    logic [39:0] name;
    logic [39:0] name_sh;
    logic [71:0] sfx;
    logic [71:0] sfx_sh;
    logic [3:0]  nl;
    logic [3:0]  sl;
    logic [3:0]  j;
    logic [7:0]  b;
    case (btn)
      3'd0:    name = "USER ";
      3'd1:    name = "LEFT ";
      3'd2:    name = "RIGHT";
      3'd3:    name = "UP   ";
      3'd4:    name = "DOWN ";
      3'd5:    name = "FIRE ";
      default: name = "MODE ";
    endcase
    nl      = 4'(name_len(btn));
    sfx     = released ? " RELEASED" : " PRESSED ";
    sl      = released ? 4'd9 : 4'd8;
    j       = k - nl;
    name_sh = name << {k[2:0], 3'b000};
    sfx_sh  = sfx << {j, 3'b000};
    if (k < nl) begin
      b = name_sh[39:32];
    end else if (j < sl) begin
      b = sfx_sh[71:64];
    end else if (j == sl) begin
      b = CH_CR;
    end else begin
      b = CH_LF;
    end
    return b;
  endfunction

endpackage

### design/lcbr_front.sv
// ----------------------------------------------------------------------------
// lcbr_front
// Takes one tick, runs the command parser, updates the LEDs and pressed flags
// and hands the classified tick to the job queue.
// ----------------------------------------------------------------------------
module lcbr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lcbr_pkg::BUTTONS-1:0]  cfg_wr_data,
  input  logic                          accept,
  input  logic                          rx_valid,
  input  logic [7:0]                    rx_byte,
  input  logic [lcbr_pkg::BUTTONS-1:0]  button_levels,
  input  logic                          tx_ready,
  output lcbr_pkg::job_t                job
);

  logic [lcbr_pkg::BUTTONS-1:0] mask_r;
  logic [1:0]                   parse_r, parse_nxt;
  logic [1:0]                   chosen_r, chosen_nxt;
  logic [3:0]                   leds_r, leds_nxt;
  logic [lcbr_pkg::BUTTONS-1:0] pressed_r, pressed_nxt;
  logic [3:0]                   led_bit;

  assign led_bit     = 4'b0001 << chosen_r;
  assign pressed_nxt = button_levels ^ mask_r;

  always_comb begin
    parse_nxt  = parse_r;
    chosen_nxt = chosen_r;
    leds_nxt   = leds_r;
    if (rx_valid) begin
      case (parse_r)
        lcbr_pkg::PARSE_LETTER: begin
          parse_nxt = lcbr_pkg::PARSE_ACTION;
          case (rx_byte)
            lcbr_pkg::CH_R:     chosen_nxt = lcbr_pkg::LED_RED;
            lcbr_pkg::CH_G:     chosen_nxt = lcbr_pkg::LED_GREEN;
            lcbr_pkg::CH_B:     chosen_nxt = lcbr_pkg::LED_BLUE;
            lcbr_pkg::CH_G_LOW: chosen_nxt = lcbr_pkg::LED_GREEN2;
            default:            parse_nxt  = lcbr_pkg::PARSE_START;
          endcase
        end
        lcbr_pkg::PARSE_ACTION: begin
          parse_nxt = lcbr_pkg::PARSE_START;
          case (rx_byte)
            lcbr_pkg::CH_ZERO: leds_nxt = leds_r & ~led_bit;
            lcbr_pkg::CH_ONE:  leds_nxt = leds_r | led_bit;
            lcbr_pkg::CH_T:    leds_nxt = leds_r ^ led_bit;
            default:           leds_nxt = leds_r;
          endcase
        end
        default: begin
          parse_nxt = (rx_byte == lcbr_pkg::CH_L) ? lcbr_pkg::PARSE_LETTER
                                                  : lcbr_pkg::PARSE_START;
        end
      endcase
    end
  end

  always_comb begin
    job.leds     = leds_nxt;
    job.changed  = pressed_nxt ^ pressed_r;
    job.pressed  = pressed_nxt;
    job.tx_ready = tx_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= lcbr_pkg::BUTTONS'(63);
      parse_r   <= lcbr_pkg::PARSE_START;
      chosen_r  <= lcbr_pkg::LED_RED;
      leds_r    <= '0;
      pressed_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
      if (accept) begin
        parse_r   <= parse_nxt;
        chosen_r  <= chosen_nxt;
        leds_r    <= leds_nxt;
        pressed_r <= pressed_nxt;
      end
    end
  end

endmodule

### design/lcbr_job_fifo.sv
// ----------------------------------------------------------------------------
// lcbr_job_fifo
// Two-entry queue of classified ticks between the front and back ends.
// ----------------------------------------------------------------------------
module lcbr_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lcbr_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output lcbr_pkg::job_t pop_job
);

  lcbr_pkg::job_t slot_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;

  assign full    = (count_r == 2'd2);
  assign avail   = (count_r != 2'd0);
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### design/lcbr_back.sv
// ----------------------------------------------------------------------------
// lcbr_back
// Scans button changes, copies message text into the ring buffer one byte a
// cycle, sends at most one byte per tick and registers the tick's result.
// ----------------------------------------------------------------------------
module lcbr_back #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           avail,
  input  lcbr_pkg::job_t job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [3:0]     out_leds,
  output logic           out_tx_valid,
  output logic [7:0]     out_tx_char,
  output logic [7:0]     out_queue_level,
  output logic           out_message_dropped
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW:0]   DEPTH_V  = (CW + 1)'(QUEUE_DEPTH);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_COPY   = 3'd2;
  localparam logic [2:0] ST_XMIT   = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [7:0]     mem [QUEUE_DEPTH];
  logic [7:0]     rdata_r;

  logic [2:0]     state_r;
  lcbr_pkg::job_t job_r;
  logic [2:0]     btn_r;
  logic [3:0]     k_r;
  logic           dropped_r;
  logic           txv_r;
  logic [AW-1:0]  wr_idx_r;
  logic [AW-1:0]  rd_idx_r;
  logic [CW-1:0]  fill_r;
  logic           out_valid_r;
  logic [3:0]     leds_out_r;
  logic           txv_out_r;
  logic [7:0]     txc_out_r;
  logic [7:0]     level_out_r;
  logic           drop_out_r;

  logic           released;
  logic [4:0]     len;
  logic           fits;
  logic           last_btn;
  logic           do_write;
  logic           do_read;
  logic           out_free;
  logic [CW+7:0]  level_wide;

  assign released   = ~job_r.pressed[btn_r];
  assign len        = lcbr_pkg::msg_len(btn_r, released);
  assign fits       = ({1'b0, fill_r} + (CW + 1)'(len)) <= DEPTH_V;
  assign last_btn   = (btn_r == 3'(lcbr_pkg::BUTTONS - 1));
  assign do_write   = (state_r == ST_COPY);
  assign do_read    = (state_r == ST_XMIT) && job_r.tx_ready && (fill_r != '0);
  assign pop        = (state_r == ST_IDLE) && avail;
  assign out_free   = !out_valid_r || !out_stall;
  assign level_wide = {8'd0, fill_r};

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_idx_r] <= lcbr_pkg::msg_byte(btn_r, released, k_r);
    end
    if (do_read) begin
      rdata_r <= mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= job;
    end
    if (state_r == ST_RESULT && out_free) begin
      leds_out_r  <= job_r.leds;
      txv_out_r   <= txv_r;
      txc_out_r   <= txv_r ? rdata_r : 8'd0;
      level_out_r <= level_wide[7:0];
      drop_out_r  <= dropped_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      btn_r       <= 3'd0;
      k_r         <= 4'd0;
      dropped_r   <= 1'b0;
      txv_r       <= 1'b0;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (avail) begin
            btn_r     <= 3'd0;
            dropped_r <= 1'b0;
            state_r   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (job_r.changed[btn_r] && fits) begin
            k_r     <= 4'd0;
            state_r <= ST_COPY;
          end else begin
            if (job_r.changed[btn_r]) begin
              dropped_r <= 1'b1;
            end
            btn_r   <= btn_r + 3'd1;
            state_r <= last_btn ? ST_XMIT : ST_SCAN;
          end
        end
        ST_COPY: begin
          wr_idx_r <= (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + AW'(1);
          fill_r   <= fill_r + CW'(1);
          k_r      <= k_r + 4'd1;
          if ({1'b0, k_r} == len - 5'd1) begin
            btn_r   <= btn_r + 3'd1;
            state_r <= last_btn ? ST_XMIT : ST_SCAN;
          end
        end
        ST_XMIT: begin
          txv_r <= do_read;
          if (do_read) begin
            rd_idx_r <= (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + AW'(1);
            fill_r   <= fill_r - CW'(1);
          end
          state_r <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_leds            = leds_out_r;
  assign out_tx_valid        = txv_out_r;
  assign out_tx_char         = txc_out_r;
  assign out_queue_level     = level_out_r;
  assign out_message_dropped = drop_out_r;

endmodule

### design/led_command_and_button_reporter.sv
// ----------------------------------------------------------------------------
// led_command_and_button_reporter
// LED command parser and button change reporter with a ring message buffer.
// ----------------------------------------------------------------------------
// Each tick passes the front end, the job queue and the back end, where the
// seven-step button scan copies each changed button's message into the ring
// buffer one byte at a time through its single write port (up to 104 bytes
// when every button changes).
// The front end takes a new tick while the back end works, through a
// two-entry job queue. Synchronous active-low reset clears LEDs, flags,
// parser and buffer pointers; buffer contents are not cleared.
// ----------------------------------------------------------------------------
module led_command_and_button_reporter #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_rx_valid,
  input  logic [7:0] in_rx_byte,
  input  logic [6:0] in_button_levels,
  input  logic       in_tx_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_led_red,
  output logic       out_led_green,
  output logic       out_led_blue,
  output logic       out_led_second_green,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_char,
  output logic [7:0] out_queue_level,
  output logic       out_message_dropped
);

  lcbr_pkg::job_t front_job;
  lcbr_pkg::job_t back_job;
  logic           fifo_full;
  logic           fifo_avail;
  logic           fifo_pop;
  logic           accept;
  logic [3:0]     leds;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;

  lcbr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .accept        (accept),
    .rx_valid      (in_rx_valid),
    .rx_byte       (in_rx_byte),
    .button_levels (in_button_levels),
    .tx_ready      (in_tx_ready),
    .job           (front_job)
  );

  lcbr_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_job (front_job),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .avail    (fifo_avail),
    .pop_job  (back_job)
  );

  lcbr_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .avail               (fifo_avail),
    .job                 (back_job),
    .pop                 (fifo_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_leds            (leds),
    .out_tx_valid        (out_tx_valid),
    .out_tx_char         (out_tx_char),
    .out_queue_level     (out_queue_level),
    .out_message_dropped (out_message_dropped)
  );

  assign out_led_red          = leds[0];
  assign out_led_green        = leds[1];
  assign out_led_blue         = leds[2];
  assign out_led_second_green = leds[3];

endmodule

### design/lcbr_checker.sv
// ----------------------------------------------------------------------------
// lcbr_checker
// Port-level checks of the reporter's result channel.
// ----------------------------------------------------------------------------
module lcbr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_led_red,
  input logic       out_led_green,
  input logic       out_led_blue,
  input logic       out_led_second_green,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_char,
  input logic [7:0] out_queue_level,
  input logic       out_message_dropped
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // idle transmit slot carries a zero byte
  a_idle_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_char == 8'd0)
    else $error("tx_char nonzero without tx_valid");

  // message text holds no zero bytes, so a sent byte is never zero
  a_sent_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |-> out_tx_char != 8'd0)
    else $error("zero byte sent from message buffer");

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_char)
      && $stable(out_tx_valid) && $stable(out_queue_level)
      && $stable(out_message_dropped) && $stable(out_led_red)
      && $stable(out_led_green) && $stable(out_led_blue)
      && $stable(out_led_second_green))
    else $error("stalled result changed");

endmodule

bind led_command_and_button_reporter lcbr_checker u_lcbr_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_led_red          (out_led_red),
  .out_led_green        (out_led_green),
  .out_led_blue         (out_led_blue),
  .out_led_second_green (out_led_second_green),
  .out_tx_valid         (out_tx_valid),
  .out_tx_char          (out_tx_char),
  .out_queue_level      (out_queue_level),
  .out_message_dropped  (out_message_dropped)
);

### verif/led_command_and_button_reporter_test.sv
// ----------------------------------------------------------------------------
// led_command_and_button_reporter_test
// Drives command bytes, button levels and transmitter-ready ticks into the
// reporter and checks every result word against a typed row or an in-bench
// copy of the parser, the button scan and the message ring. A short table
// of directed ticks comes first, then random phases under several polarity
// masks, with stalls on both channels and one long output hold.
// ----------------------------------------------------------------------------
module led_command_and_button_reporter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH  = 128;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 120;
  localparam int PHASE_ITEMS = 190;
  localparam int LAST_PHASE  = 5;
  localparam int HOLD_PHASE  = 2;
  localparam int PAUSE_PHASE = 3;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [6:0] levels;
    logic       tx_ready;
  } tick_t;

  typedef struct packed {
    logic       red;
    logic       green;
    logic       blue;
    logic       green2;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic [7:0] level;
    logic       dropped;
  } report_t;

  typedef struct packed {
    tick_t   stim;
    logic    typed;
    report_t want;
  } row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [6:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic       in_rx_valid;
  logic [7:0] in_rx_byte;
  logic [6:0] in_button_levels;
  logic       in_tx_ready;
  logic       out_valid;
  logic       out_stall;
  logic       out_led_red;
  logic       out_led_green;
  logic       out_led_blue;
  logic       out_led_second_green;
  logic       out_tx_valid;
  logic [7:0] out_tx_char;
  logic [7:0] out_queue_level;
  logic       out_message_dropped;

  // typed expectation travelling with the word on the input channel
  logic       row_typed;
  report_t    row_want;

  // predictor state
  logic [6:0] mask_q;
  logic [1:0] parse_q;
  logic [1:0] led_sel_q;
  logic [3:0] leds_q;
  logic [6:0] pressed_q;
  logic [7:0] ring_q [RING_DEPTH];
  logic [6:0] wr_ptr;
  logic [6:0] rd_ptr;
  int         fill_q;

  report_t    pending_reports[$];
  row_t       script[$];
  int         errors;
  int         quiet_cycles;
  int         phase;
  bit         bursts_on;
  int         cmd_pos;
  logic [6:0] level_now;

  led_command_and_button_reporter #(
    .QUEUE_DEPTH(RING_DEPTH)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_valid         (in_rx_valid),
    .in_rx_byte          (in_rx_byte),
    .in_button_levels    (in_button_levels),
    .in_tx_ready         (in_tx_ready),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_led_red         (out_led_red),
    .out_led_green       (out_led_green),
    .out_led_blue        (out_led_blue),
    .out_led_second_green(out_led_second_green),
    .out_tx_valid        (out_tx_valid),
    .out_tx_char         (out_tx_char),
    .out_queue_level     (out_queue_level),
    .out_message_dropped (out_message_dropped)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic string key_label(input int btn);
    case (btn)
      0:       return "USER";
      1:       return "LEFT";
      2:       return "RIGHT";
      3:       return "UP";
      4:       return "DOWN";
      5:       return "FIRE";
      default: return "MODE";
    endcase
  endfunction

  // one tick: parser, then button scan into the ring, then transmit
  task automatic step_panel(input tick_t t, output report_t r);
    string      body;
    string      suffix;
    int         len;
    int         i;
    int         k;
    logic       now;
    logic [3:0] bit_sel;
    r = '0;
    if (t.rx_valid) begin
      case (parse_q)
        lcbr_pkg::PARSE_LETTER: begin
          parse_q = lcbr_pkg::PARSE_ACTION;
          case (t.rx_byte)
            lcbr_pkg::CH_R:     led_sel_q = lcbr_pkg::LED_RED;
            lcbr_pkg::CH_G:     led_sel_q = lcbr_pkg::LED_GREEN;
            lcbr_pkg::CH_B:     led_sel_q = lcbr_pkg::LED_BLUE;
            lcbr_pkg::CH_G_LOW: led_sel_q = lcbr_pkg::LED_GREEN2;
            default:            parse_q = lcbr_pkg::PARSE_START;
          endcase
        end
        lcbr_pkg::PARSE_ACTION: begin
          bit_sel = 4'b0001 << led_sel_q;
          case (t.rx_byte)
            lcbr_pkg::CH_ZERO: leds_q = leds_q & ~bit_sel;
            lcbr_pkg::CH_ONE:  leds_q = leds_q | bit_sel;
            lcbr_pkg::CH_T:    leds_q = leds_q ^ bit_sel;
            default: ;
          endcase
          parse_q = lcbr_pkg::PARSE_START;
        end
        default: parse_q = (t.rx_byte == lcbr_pkg::CH_L) ? lcbr_pkg::PARSE_LETTER
                                                         : lcbr_pkg::PARSE_START;
      endcase
    end
    for (i = 0; i < lcbr_pkg::BUTTONS; i++) begin
      now = t.levels[i] ^ mask_q[i];
      if (now != pressed_q[i]) begin
        pressed_q[i] = now;
        if (now) suffix = " PRESSED";
        else     suffix = " RELEASED";
        body = {key_label(i), suffix};
        len  = body.len() + 2;
        // drop the whole message when it does not fit
        if (fill_q + len > RING_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          for (k = 0; k < len; k++) begin
            ring_q[wr_ptr] = (k < body.len()) ? body[k] :
                             ((k == body.len()) ? lcbr_pkg::CH_CR : lcbr_pkg::CH_LF);
            wr_ptr = wr_ptr + 7'd1;
          end
          fill_q += len;
        end
      end
    end
    if (t.tx_ready && fill_q > 0) begin
      r.tx_valid = 1'b1;
      r.tx_char  = ring_q[rd_ptr];
      rd_ptr     = rd_ptr + 7'd1;
      fill_q--;
    end
    r.red    = leds_q[lcbr_pkg::LED_RED];
    r.green  = leds_q[lcbr_pkg::LED_GREEN];
    r.blue   = leds_q[lcbr_pkg::LED_BLUE];
    r.green2 = leds_q[lcbr_pkg::LED_GREEN2];
    r.level  = 8'(fill_q);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic add_row(input logic rv, input logic [7:0] rb, input logic [6:0] lv,
                         input logic tr, input logic typed, input report_t want);
    row_t row;
    row.stim  = {rv, rb, lv, tr};
    row.typed = typed;
    row.want  = want;
    script.push_back(row);
  endtask

  task automatic send_tick(input tick_t t, input logic typed, input report_t want);
    in_valid         <= 1'b1;
    in_rx_valid      <= t.rx_valid;
    in_rx_byte       <= t.rx_byte;
    in_button_levels <= t.levels;
    in_tx_ready      <= t.tx_ready;
    row_typed        <= typed;
    row_want         <= want;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drain_reports;
    in_valid <= 1'b0;
    // let the monitor book the last accepted word first
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mask(input logic [6:0] m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mask_q = m;
  endtask

  // mostly well-formed commands, some junk; buttons change now and then
  task automatic make_tick(output tick_t t);
    int pick;
    pick       = $urandom_range(0, 99);
    t.rx_byte  = 8'($urandom_range(0, 255));
    t.rx_valid = 1'b0;
    if (pick < 55) begin
      t.rx_valid = 1'b1;
      case (cmd_pos)
        0: t.rx_byte = lcbr_pkg::CH_L;
        1: begin
          case ($urandom_range(0, 3))
            0:       t.rx_byte = lcbr_pkg::CH_R;
            1:       t.rx_byte = lcbr_pkg::CH_G;
            2:       t.rx_byte = lcbr_pkg::CH_B;
            default: t.rx_byte = lcbr_pkg::CH_G_LOW;
          endcase
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       t.rx_byte = lcbr_pkg::CH_ZERO;
            1:       t.rx_byte = lcbr_pkg::CH_ONE;
            default: t.rx_byte = lcbr_pkg::CH_T;
          endcase
        end
      endcase
      cmd_pos = (cmd_pos + 1) % 3;
    end else if (pick >= 90) begin
      t.rx_valid = 1'b1;
      cmd_pos    = 0;
    end
    pick = $urandom_range(0, 199);
    if (pick < 1) begin
      level_now = 7'($urandom);
    end else if (pick < 9) begin
      level_now = level_now ^ (7'd1 << $urandom_range(0, lcbr_pkg::BUTTONS - 1));
    end
    t.levels   = level_now;
    t.tx_ready = ($urandom_range(0, 19) < 17);
  endtask

  always @(posedge clk) begin : monitor
    tick_t   seen;
    report_t guess;
    report_t head;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_reports.size() == 0) begin
          errors++;
          $display("%0t: result word expected none, got tx_char %0d level %0d", $time,
                   out_tx_char, out_queue_level);
        end else begin
          head = pending_reports.pop_front();
          check_field("led_red", head.red, out_led_red);
          check_field("led_green", head.green, out_led_green);
          check_field("led_blue", head.blue, out_led_blue);
          check_field("led_second_green", head.green2, out_led_second_green);
          check_field("tx_valid", head.tx_valid, out_tx_valid);
          check_field("tx_char", head.tx_char, out_tx_char);
          check_field("queue_level", head.level, out_queue_level);
          check_field("message_dropped", head.dropped, out_message_dropped);
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        seen = {in_rx_valid, in_rx_byte, in_button_levels, in_tx_ready};
        step_panel(seen, guess);
        pending_reports.push_back(row_typed ? row_want : guess);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n !== 1'b1 || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("led_command_and_button_reporter_test: done, errors");
        $finish;
      end
    end
  end

  initial begin : receiver
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (phase == HOLD_PHASE && !held) begin
        // hold off long enough for the block to back up into its input
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    report_t quiet;
    report_t red_only;
    tick_t   t;
    int      p;
    int      n;
    errors       = 0;
    quiet_cycles = 0;
    phase        = 0;
    bursts_on    = 1'b0;
    cmd_pos      = 0;
    level_now    = 7'h3F;
    mask_q       = 7'h3F;
    parse_q      = lcbr_pkg::PARSE_START;
    led_sel_q    = lcbr_pkg::LED_RED;
    leds_q       = 4'd0;
    pressed_q    = 7'd0;
    wr_ptr       = 7'd0;
    rd_ptr       = 7'd0;
    fill_q       = 0;

    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= 7'd0;
    in_valid         <= 1'b0;
    in_rx_valid      <= 1'b0;
    in_rx_byte       <= 8'd0;
    in_button_levels <= 7'h3F;
    in_tx_ready      <= 1'b0;
    row_typed        <= 1'b0;
    row_want         <= '0;

    quiet        = '0;
    red_only     = '0;
    red_only.red = 1'b1;

    // idle levels under the reset mask read as all released
    add_row(1'b1, 8'h00,              7'h3F, 1'b1, 1'b1, quiet);
    add_row(1'b1, lcbr_pkg::CH_L,     7'h3F, 1'b0, 1'b1, quiet);
    add_row(1'b1, lcbr_pkg::CH_R,     7'h3F, 1'b0, 1'b1, quiet);
    add_row(1'b1, lcbr_pkg::CH_ONE,   7'h3F, 1'b0, 1'b1, red_only);
    add_row(1'b0, lcbr_pkg::CH_L,     7'h3F, 1'b1, 1'b1, red_only);
    add_row(1'b1, lcbr_pkg::CH_L,     7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_G,     7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_T,     7'h3F, 1'b1, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_L,     7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_B,     7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_ONE,   7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_L,     7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_G_LOW, 7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_T,     7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_L,     7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_R,     7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_ZERO,  7'h3F, 1'b0, 1'b0, quiet);
    // bad letter restarts the parser and is not taken as a new lead-in
    add_row(1'b1, lcbr_pkg::CH_L,     7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_L,     7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_G,     7'h3F, 1'b0, 1'b0, quiet);
    // bad third character still ends the command
    add_row(1'b1, lcbr_pkg::CH_L,     7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, lcbr_pkg::CH_R,     7'h3F, 1'b0, 1'b0, quiet);
    add_row(1'b1, 8'hFF,              7'h3F, 1'b0, 1'b0, quiet);
    // press six buttons, then flip all seven so the ring overflows
    add_row(1'b0, 8'hFF,              7'h00, 1'b1, 1'b0, quiet);
    add_row(1'b0, 8'h00,              7'h7F, 1'b1, 1'b0, quiet);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mask(7'h3F);
    bursts_on = 1'b1;
    foreach (script[j]) begin
      send_tick(script[j].stim, script[j].typed, script[j].want);
    end
    drain_reports();

    for (p = 1; p <= LAST_PHASE; p++) begin
      phase = p;
      case (p)
        1:          write_mask(7'h00);
        2:          write_mask(7'h7F);
        LAST_PHASE: write_mask(7'h3F);
        default:    write_mask(7'($urandom));
      endcase
      bursts_on = (p != LAST_PHASE);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
          drain_reports();
        end
        make_tick(t);
        send_tick(t, 1'b0, quiet);
      end
      drain_reports();
    end

    if (errors == 0) begin
      $display("led_command_and_button_reporter_test: done, clean");
    end else begin
      $display("led_command_and_button_reporter_test: done, errors");
    end
    $finish;
  end

endmodule
